// ===== design/tcq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcq_pkg: shared types and constants of the timed command queue
// Slot count, command and status codes, transfer payloads, the entry held
// by one cell and the control broadcast from the top level to every cell.
// ----------------------------------------------------------------------------
package tcq_pkg;

    localparam int SLOTS = 10;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [7:0] EMPTY_MARK = 8'hFF;

    // command codes
    localparam logic [1:0] CMD_INSERT   = 2'd0;
    localparam logic [1:0] CMD_COMPLETE = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;
    localparam logic [1:0] CMD_NONE     = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;
    localparam logic [1:0] STAT_BAD_CODE = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] mission_code;
        logic [7:0] delay_minutes;
        logic [7:0] cmd_detail;
        logic [7:0] elapsed_minutes;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] next_code;
        logic [7:0] next_delay;
        logic [7:0] next_detail;
        logic [3:0] pending_count;
        logic       pending;
    } t_out;

    typedef struct packed {
        logic       valid;
        logic [7:0] code;
        logic [7:0] delay;
        logic [7:0] detail;
    } t_entry;

    typedef struct packed {
        logic [1:0] op;
        logic       age_en;
        logic [7:0] elapsed;
        logic [7:0] head_delay;
        t_entry     ins;
    } t_cell_ctrl;

    // subtract, saturating at zero
    function automatic logic [7:0] sat_sub(input logic [7:0] a, input logic [7:0] b);
        sat_sub = (a > b) ? (a - b) : 8'd0;
    endfunction

endpackage

// ===== design/tcq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcq_cell: one slot of the sorted reservation chain
// Holds one entry. On insert it ages its delay, decides whether the new
// entry lands at or before it, and keeps its aged entry or takes the new
// entry or its left neighbor's. Complete takes the right neighbor's; clear drops it.
// ----------------------------------------------------------------------------
module tcq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcq_pkg::t_cell_ctrl i_ctrl,
    input  tcq_pkg::t_entry     i_prev_aged,
    input  logic                i_prev_take,
    input  tcq_pkg::t_entry     i_next,
    output tcq_pkg::t_entry     o_entry,
    output tcq_pkg::t_entry     o_aged,
    output logic                o_take
);

    tcq_pkg::t_entry r_entry;
    tcq_pkg::t_entry n_entry;
    tcq_pkg::t_entry w_aged;
    logic            w_take;

    // age the held delay by the elapsed minutes
    always_comb begin
        w_aged = r_entry;
        if (i_ctrl.age_en) begin
            w_aged.delay = tcq_pkg::sat_sub(r_entry.delay, i_ctrl.elapsed);
        end
    end

    // new entry goes before this one when this slot is empty or later
    assign w_take = !r_entry.valid || (w_aged.delay > i_ctrl.ins.delay);

    // select next entry
    always_comb begin
        n_entry = r_entry;
        case (i_ctrl.op)
            tcq_pkg::CMD_INSERT: begin
                if (!w_take) begin
                    n_entry = w_aged;
                end else if (!i_prev_take) begin
                    n_entry = i_ctrl.ins;
                end else begin
                    n_entry = i_prev_aged;
                end
            end
            tcq_pkg::CMD_COMPLETE: begin
                n_entry       = i_next;
                n_entry.delay = tcq_pkg::sat_sub(i_next.delay, i_ctrl.head_delay);
            end
            tcq_pkg::CMD_CLEAR: begin
                n_entry.valid = 1'b0;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // hold entry; reset clears only the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.code   <= n_entry.code;
        r_entry.delay  <= n_entry.delay;
        r_entry.detail <= n_entry.detail;
    end

    assign o_entry = r_entry;
    assign o_aged  = w_aged;
    assign o_take  = w_take;

endmodule

// ===== design/timed_command_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_command_queue: sorted queue of timed command reservations
// Chain of slot cells kept in ascending delay order, with a small
// controller that checks each command and reports the head entry.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one command:
//   insert, complete head or clear. Output channel (o_out_valid /
//   i_out_ready / o_out_data) returns one report per command: status, head
//   entry (all 255 when empty), count and pending flag.
//   A command passes the execute and report states before its report is
//   registered, and no new command is taken before then. The cells update
//   in parallel in the execute state, so latency does not depend on fill level.
//   The next command is taken while a report still waits in the output
//   register; if the receiver stalls long enough for a second report to be
//   ready, the block holds it and stops taking commands until the first one
//   transfers.
//   Reset empties all slots, clears the count and turns aging off; the block
//   is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module timed_command_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tcq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tcq_pkg::t_out o_out_data
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EXEC   = 3'b010,
        ST_REPORT = 3'b100
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    tcq_pkg::t_in              r_item;
    logic [tcq_pkg::CNT_W-1:0] r_count;
    logic [tcq_pkg::CNT_W-1:0] n_count;
    logic                      r_aging;
    logic                      n_aging;
    logic [1:0]                r_status;
    logic [1:0]                n_status;
    logic                      r_out_valid;
    tcq_pkg::t_out             r_out;
    tcq_pkg::t_out             n_out;
    tcq_pkg::t_cell_ctrl       w_ctrl;
    logic                      w_load;

    tcq_pkg::t_entry           w_entry [tcq_pkg::SLOTS];
    tcq_pkg::t_entry           w_aged  [tcq_pkg::SLOTS];
    logic [tcq_pkg::SLOTS-1:0] w_take;
    logic [tcq_pkg::SLOTS-1:0] w_valid;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_load     = (r_state == ST_REPORT) && (!r_out_valid || i_out_ready);

    // check the command and issue it to the cells
    always_comb begin
        n_status = tcq_pkg::STAT_OK;
        n_count  = r_count;
        n_aging  = r_aging;
        w_ctrl.op         = tcq_pkg::CMD_NONE;
        w_ctrl.age_en     = r_aging;
        w_ctrl.elapsed    = r_item.elapsed_minutes;
        w_ctrl.head_delay = w_entry[0].delay;
        w_ctrl.ins.valid  = 1'b1;
        w_ctrl.ins.code   = r_item.mission_code;
        w_ctrl.ins.delay  = r_item.delay_minutes;
        w_ctrl.ins.detail = r_item.cmd_detail;
        if (r_state == ST_EXEC) begin
            case (r_item.cmd)
                tcq_pkg::CMD_INSERT: begin
                    if (r_item.mission_code == tcq_pkg::EMPTY_MARK) begin
                        n_status = tcq_pkg::STAT_BAD_CODE;
                    end else if (r_count == tcq_pkg::CNT_W'(tcq_pkg::SLOTS)) begin
                        n_status = tcq_pkg::STAT_FULL;
                    end else begin
                        w_ctrl.op = tcq_pkg::CMD_INSERT;
                        n_count   = r_count + 1'b1;
                        n_aging   = 1'b1;
                    end
                end
                tcq_pkg::CMD_COMPLETE: begin
                    if (r_count == '0) begin
                        n_status = tcq_pkg::STAT_EMPTY;
                    end else begin
                        w_ctrl.op = tcq_pkg::CMD_COMPLETE;
                        n_count   = r_count - 1'b1;
                    end
                end
                tcq_pkg::CMD_CLEAR: begin
                    w_ctrl.op = tcq_pkg::CMD_CLEAR;
                    n_count   = '0;
                    n_aging   = 1'b0;
                end
                default: begin
                    w_ctrl.op = tcq_pkg::CMD_NONE;
                end
            endcase
        end
    end

    // chain of slot cells
    for (genvar k = 0; k < tcq_pkg::SLOTS; k++) begin : g_cell
        tcq_pkg::t_entry w_prev_aged;
        logic            w_prev_take;
        tcq_pkg::t_entry w_next;

        if (k == 0) begin : g_first
            assign w_prev_aged = '0;
            assign w_prev_take = 1'b0;
        end else begin : g_inner
            assign w_prev_aged = w_aged[k-1];
            assign w_prev_take = w_take[k-1];
        end

        if (k == tcq_pkg::SLOTS - 1) begin : g_last
            assign w_next = '{valid: 1'b0, code: tcq_pkg::EMPTY_MARK,
                              delay: tcq_pkg::EMPTY_MARK, detail: tcq_pkg::EMPTY_MARK};
        end else begin : g_mid
            assign w_next = w_entry[k+1];
        end

        tcq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_prev_aged (w_prev_aged),
            .i_prev_take (w_prev_take),
            .i_next      (w_next),
            .o_entry     (w_entry[k]),
            .o_aged      (w_aged[k]),
            .o_take      (w_take[k])
        );

        assign w_valid[k] = w_entry[k].valid;
    end

    // build the report from the head cell
    always_comb begin
        n_out.status        = r_status;
        n_out.next_code     = w_entry[0].valid ? w_entry[0].code   : tcq_pkg::EMPTY_MARK;
        n_out.next_delay    = w_entry[0].valid ? w_entry[0].delay  : tcq_pkg::EMPTY_MARK;
        n_out.next_detail   = w_entry[0].valid ? w_entry[0].detail : tcq_pkg::EMPTY_MARK;
        n_out.pending_count = 4'(r_count);
        n_out.pending       = (r_count != '0);
    end

    // advance the command sequence
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_REPORT;
            end
            ST_REPORT: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_aging     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_aging <= n_aging;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_data;
        end
        if (r_state == ST_EXEC) begin
            r_status <= n_status;
        end
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    // one held entry per counted reservation
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == r_count)
        else $error("cell valid bits disagree with held count");

    // count never exceeds the slot count
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tcq_pkg::CNT_W'(tcq_pkg::SLOTS))
        else $error("held count above slot count");

    // head is never later than the second entry
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[1] |-> (w_entry[0].delay <= w_entry[1].delay))
        else $error("queue head out of delay order");

    // an input transfer always starts execution next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_EXEC))
        else $error("accepted command not executed");
`endif

endmodule
